>>> src/rcd_pkg.sv
// Shared types, tag constants and helper functions for the RMID chunk demux.
// No dependencies; rcd_front, rcd_queue, rcd_back and the top level use it.
`default_nettype none
package rcd_pkg;

    // Result kinds
    localparam logic [2:0] K_MIDI  = 3'd0;
    localparam logic [2:0] K_BANK  = 3'd1;
    localparam logic [2:0] K_INFO  = 3'd2;
    localparam logic [2:0] K_EMPTY = 3'd3;
    localparam logic [2:0] K_ERROR = 3'd4;
    localparam logic [2:0] K_DONE  = 3'd5;

    // Info field codes
    localparam logic [3:0] FC_NAME      = 4'd0;
    localparam logic [3:0] FC_ARTIST    = 4'd1;
    localparam logic [3:0] FC_ALBUM     = 4'd2;
    localparam logic [3:0] FC_GENRE     = 4'd3;
    localparam logic [3:0] FC_PICTURE   = 4'd4;
    localparam logic [3:0] FC_COPYRIGHT = 4'd5;
    localparam logic [3:0] FC_COMMENT   = 4'd6;
    localparam logic [3:0] FC_DATE      = 4'd7;
    localparam logic [3:0] FC_ENCODING  = 4'd8;
    localparam logic [3:0] FC_ENGINEER  = 4'd9;
    localparam logic [3:0] FC_SOFTWARE  = 4'd10;
    localparam logic [3:0] FC_SUBJECT   = 4'd11;
    localparam logic [3:0] FC_MIDI_ENC  = 4'd12;
    localparam logic [3:0] FC_DBNK      = 4'd13;
    localparam logic [3:0] FC_NONE      = 4'd14;

    // Header replay length and last index
    localparam int          HDR_LEN  = 12;
    localparam logic [3:0]  HDR_LAST = 4'd11;
    localparam logic [31:0] HEAD_LEN = 32'd20;

    typedef logic [HDR_LEN-1:0][7:0] t_hdr;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [3:0]  field_code;
        logic        first_of_region;
        logic        last_of_region;
        logic [15:0] bank_ofs;
        logic        bank_is_dls;
        logic        has_bank;
    } t_res;

    // Work handed from the parser to the output sequencer for one byte
    typedef struct packed {
        logic        main_vld;
        logic [2:0]  main_kind;
        logic [7:0]  main_byte;
        logic [3:0]  main_code;
        logic        main_first;
        logic        main_last;
        logic        replay;
        logic        replay_last;
        t_hdr        hdr;
        logic        done_vld;
        logic [15:0] done_off;
        logic        done_dls;
        logic        done_has;
    } t_cmd;

    // Four bytes starting at i, first byte in the top lane
    function automatic logic [31:0] tag_at(input t_hdr hb, input logic [3:0] i);
        tag_at = {hb[i], hb[i + 4'd1], hb[i + 4'd2], hb[i + 4'd3]};
    endfunction

    // Little-endian word starting at i
    function automatic logic [31:0] le32_at(input t_hdr hb, input logic [3:0] i);
        le32_at = {hb[i + 4'd3], hb[i + 4'd2], hb[i + 4'd1], hb[i]};
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [31:0] tag_lower(input logic [31:0] t);
        tag_lower = {to_lower(t[31:24]), to_lower(t[23:16]),
                     to_lower(t[15:8]), to_lower(t[7:0])};
    endfunction

    // Map a field tag to its code
    function automatic logic [3:0] field_of(input logic [31:0] t);
        case (t)
            "INAM":  field_of = FC_NAME;
            "IART":  field_of = FC_ARTIST;
            "IALB":  field_of = FC_ALBUM;
            "IPRD":  field_of = FC_ALBUM;
            "IGNR":  field_of = FC_GENRE;
            "IPIC":  field_of = FC_PICTURE;
            "ICOP":  field_of = FC_COPYRIGHT;
            "ICMT":  field_of = FC_COMMENT;
            "ICRD":  field_of = FC_DATE;
            "ICRT":  field_of = FC_DATE;
            "IENC":  field_of = FC_ENCODING;
            "IENG":  field_of = FC_ENGINEER;
            "ISFT":  field_of = FC_SOFTWARE;
            "ISBJ":  field_of = FC_SUBJECT;
            "MENC":  field_of = FC_MIDI_ENC;
            "DBNK":  field_of = FC_DBNK;
            default: field_of = FC_NONE;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> src/rcd_in_if.sv
// Input byte channel: valid/ready plus one file byte.
// No dependencies.
`default_nettype none
interface rcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

>>> src/rcd_out_if.sv
// Result channel: valid/ready plus the result fields.
// No dependencies.
`default_nettype none
interface rcd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [3:0]  field_code;
    logic        first_of_region;
    logic        last_of_region;
    logic [15:0] bank_ofs;
    logic        bank_is_dls;
    logic        has_bank;

    modport source (output valid, output kind, output out_byte, output field_code,
                    output first_of_region, output last_of_region, output bank_ofs,
                    output bank_is_dls, output has_bank, input ready);
    modport sink   (input valid, input kind, input out_byte, input field_code,
                    input first_of_region, input last_of_region, input bank_ofs,
                    input bank_is_dls, input has_bank, output ready);
endinterface
`default_nettype wire

>>> src/rcd_front.sv
// Parser front end: accepts file bytes, walks the RIFF chunk structure and
// pushes one command per producing byte. Depends on rcd_pkg and rcd_in_if.
`default_nettype none
module rcd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_file_size,
    input  wire logic          i_room,
    rcd_in_if.sink             i_in,
    output logic               o_push,
    output rcd_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        PH_HEAD, PH_PAYLOAD, PH_SKIP, PH_CHUNKHDR, PH_SUBTYPE,
        PH_LISTTYPE, PH_BANK, PH_FIELDHDR, PH_FIELDDATA, PH_TAIL
    } t_phase;

    t_phase        r_phase, n_phase, r_resume, n_resume, ph;
    logic [31:0]   r_pos;
    rcd_pkg::t_hdr r_hb, n_hb;
    logic [31:0]   r_riff, n_riff;
    logic [32:0]   r_chunk_end, n_chunk_end;
    logic [32:0]   r_list_end, n_list_end;
    logic [32:0]   r_field_end, n_field_end;
    logic [32:0]   r_skip, n_skip;
    logic [3:0]    r_field, n_field;
    logic [3:0]    r_seen, n_seen;
    logic [15:0]   r_offset, n_offset;
    logic          r_failed, n_failed;
    logic [3:0]    r_hdr, n_hdr;

    logic          acc, active, work, err;
    logic [7:0]    b;
    logic [32:0]   nx, fs;
    logic          jmp_after, jmp_field;
    logic [33:0]   jf_ip, ce_pad, sum34;
    logic [31:0]   len32;
    logic [3:0]    idx, code;
    logic          bank_dls, bank_any;
    logic [15:0]   off;
    rcd_pkg::t_cmd cmd;

    assign i_in.ready = i_room;
    assign acc    = i_in.valid & i_in.ready;
    assign b      = i_in.data_byte;
    assign nx     = {1'b0, r_pos} + 33'd1;
    assign fs     = {1'b0, i_file_size};
    assign active = acc && (r_pos < i_file_size);
    assign work   = active && !r_failed;

    // Parse one byte
    always_comb begin
        n_phase     = r_phase;
        n_resume    = r_resume;
        n_hb        = r_hb;
        n_riff      = r_riff;
        n_chunk_end = r_chunk_end;
        n_list_end  = r_list_end;
        n_field_end = r_field_end;
        n_skip      = r_skip;
        n_field     = r_field;
        n_seen      = r_seen;
        n_offset    = r_offset;
        n_failed    = r_failed;
        n_hdr       = r_hdr;
        err         = 1'b0;
        jmp_after   = 1'b0;
        jmp_field   = 1'b0;
        jf_ip       = '0;
        ce_pad      = '0;
        len32       = '0;
        idx         = '0;
        code        = rcd_pkg::FC_NONE;
        bank_dls    = 1'b0;
        bank_any    = 1'b0;
        sum34       = '0;
        cmd         = '0;

        ph = (r_phase == PH_SKIP && {1'b0, r_pos} == r_skip) ? r_resume : r_phase;
        if (work) begin
            n_phase = ph;
            case (ph)
                PH_HEAD: begin
                    if (i_file_size < rcd_pkg::HEAD_LEN) begin
                        err = 1'b1;
                    end else begin
                        idx = (r_pos < 32'd12) ? r_pos[3:0] : {1'b0, r_pos[2:0] + 3'd4};
                        n_hb[idx] = b;
                        if (r_pos >= 32'd4 && r_pos <= 32'd7) begin
                            n_riff[8*r_pos[1:0] +: 8] = r_riff[8*r_pos[1:0] +: 8] | b;
                        end
                        if (r_pos == 32'd7 && ({2'b0, n_riff} + 34'd8) > {1'b0, fs}) begin
                            err = 1'b1;
                        end
                        if (r_pos == 32'd11 && rcd_pkg::tag_at(n_hb, 4'd8) != "RMID") begin
                            err = 1'b1;
                        end
                        if (r_pos == 32'd15 && rcd_pkg::tag_at(n_hb, 4'd0) != "data") begin
                            err = 1'b1;
                        end
                        if (r_pos == 32'd19) begin
                            len32 = rcd_pkg::le32_at(n_hb, 4'd4);
                            if (len32 > i_file_size - rcd_pkg::HEAD_LEN) begin
                                err = 1'b1;
                            end else begin
                                n_chunk_end = {1'b0, len32} + 33'd20;
                                if (len32 == '0) jmp_after = 1'b1;
                                else n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    cmd.main_vld   = 1'b1;
                    cmd.main_kind  = rcd_pkg::K_MIDI;
                    cmd.main_byte  = b;
                    cmd.main_first = (r_pos == rcd_pkg::HEAD_LEN);
                    cmd.main_last  = (nx == r_chunk_end);
                    if (nx >= r_chunk_end) jmp_after = 1'b1;
                end
                PH_CHUNKHDR: begin
                    n_hb[{1'b0, r_hdr[2:0]}] = b;
                    n_hdr = r_hdr + 4'd1;
                    if (n_hdr >= 4'd8) begin
                        len32 = rcd_pkg::le32_at(n_hb, 4'd4);
                        sum34 = {1'b0, nx} + {2'b0, len32};
                        n_chunk_end = (sum34 > {1'b0, fs}) ? fs : sum34[32:0];
                        if (len32 >= 32'd4 && ({1'b0, nx} + 34'd4) <= {1'b0, fs} &&
                            rcd_pkg::tag_at(n_hb, 4'd0) == "RIFF") begin
                            n_phase = PH_SUBTYPE;
                        end else if (len32 >= 32'd4 && ({1'b0, nx} + 34'd4) <= {1'b0, fs} &&
                                     rcd_pkg::tag_at(n_hb, 4'd0) == "LIST") begin
                            n_phase = PH_LISTTYPE;
                        end else begin
                            jmp_after = 1'b1;
                        end
                    end
                end
                PH_SUBTYPE, PH_LISTTYPE: begin
                    n_hb[(r_hdr < rcd_pkg::HDR_LAST) ? r_hdr : rcd_pkg::HDR_LAST] = b;
                    n_hdr = r_hdr + 4'd1;
                    if (n_hdr >= 4'd12) begin
                        if (ph == PH_LISTTYPE) begin
                            if (rcd_pkg::tag_at(n_hb, 4'd8) == "INFO") begin
                                n_list_end = r_chunk_end;
                                jmp_field  = 1'b1;
                                jf_ip      = {1'b0, nx};
                            end else begin
                                jmp_after = 1'b1;
                            end
                        end else begin
                            bank_dls = rcd_pkg::tag_lower(rcd_pkg::tag_at(n_hb, 4'd8)) == "dls ";
                            bank_any = bank_dls ||
                                rcd_pkg::tag_lower(rcd_pkg::tag_at(n_hb, 4'd8)) == "sfbk" ||
                                rcd_pkg::tag_lower(rcd_pkg::tag_at(n_hb, 4'd8)) == "sfpk";
                            if (bank_any) begin
                                n_seen = r_seen | 4'b1000 | (bank_dls ? 4'b0100 : 4'b0001);
                                cmd.main_vld    = 1'b1;
                                cmd.main_kind   = rcd_pkg::K_BANK;
                                cmd.replay      = 1'b1;
                                cmd.replay_last = (nx >= r_chunk_end);
                                cmd.hdr         = n_hb;
                                if (nx >= r_chunk_end) jmp_after = 1'b1;
                                else n_phase = PH_BANK;
                            end else begin
                                jmp_after = 1'b1;
                            end
                        end
                    end
                end
                PH_BANK: begin
                    cmd.main_vld  = 1'b1;
                    cmd.main_kind = rcd_pkg::K_BANK;
                    cmd.main_byte = b;
                    cmd.main_last = (nx == r_chunk_end);
                    if (nx >= r_chunk_end) jmp_after = 1'b1;
                end
                PH_FIELDHDR: begin
                    n_hb[{1'b0, r_hdr[2:0]}] = b;
                    n_hdr = r_hdr + 4'd1;
                    if (n_hdr >= 4'd8) begin
                        len32 = rcd_pkg::le32_at(n_hb, 4'd4);
                        sum34 = {1'b0, nx} + {2'b0, len32};
                        n_field_end = (sum34 > {1'b0, r_list_end}) ? r_list_end : sum34[32:0];
                        code = rcd_pkg::field_of(rcd_pkg::tag_at(n_hb, 4'd0));
                        if (code == rcd_pkg::FC_DBNK) begin
                            n_seen = r_seen | 4'b0010;
                            if ((n_field_end - nx) < 33'd2) code = rcd_pkg::FC_NONE;
                        end
                        n_field = code;
                        n_hdr   = '0;
                        if (n_field_end == nx) begin
                            if (code <= rcd_pkg::FC_MIDI_ENC) begin
                                cmd.main_vld   = 1'b1;
                                cmd.main_kind  = rcd_pkg::K_EMPTY;
                                cmd.main_code  = code;
                                cmd.main_first = 1'b1;
                                cmd.main_last  = 1'b1;
                            end
                            jmp_field = 1'b1;
                            jf_ip     = {1'b0, n_field_end} + {33'b0, n_field_end[0]};
                        end else begin
                            n_phase = PH_FIELDDATA;
                        end
                    end
                end
                PH_FIELDDATA: begin
                    if (r_field <= rcd_pkg::FC_MIDI_ENC) begin
                        cmd.main_vld   = 1'b1;
                        cmd.main_kind  = rcd_pkg::K_INFO;
                        cmd.main_byte  = b;
                        cmd.main_code  = r_field;
                        cmd.main_first = (r_hdr == 4'd0);
                        cmd.main_last  = (nx == r_field_end);
                    end else if (r_field == rcd_pkg::FC_DBNK) begin
                        if (r_hdr == 4'd0) n_offset[7:0] = b;
                        else if (r_hdr == 4'd1) n_offset[15:8] = b;
                    end
                    if (r_hdr < 4'd2) n_hdr = r_hdr + 4'd1;
                    if (nx >= r_field_end) begin
                        jmp_field = 1'b1;
                        jf_ip     = {1'b0, r_field_end} + {33'b0, r_field_end[0]};
                    end
                end
                default: begin
                end
            endcase

            // Resolve jumps to the next field or the next chunk
            if (jmp_field) begin
                if (jf_ip + 34'd8 <= {1'b0, n_list_end}) begin
                    n_hdr    = '0;
                    n_skip   = jf_ip[32:0];
                    n_resume = PH_FIELDHDR;
                    n_phase  = PH_SKIP;
                end else begin
                    jmp_after = 1'b1;
                end
            end
            ce_pad = {1'b0, n_chunk_end} + {33'b0, n_chunk_end[0]};
            if (jmp_after) begin
                if (n_chunk_end >= fs || ce_pad + 34'd8 > {1'b0, fs}) begin
                    n_phase = PH_TAIL;
                end else begin
                    n_hdr    = '0;
                    n_skip   = ce_pad[32:0];
                    n_resume = PH_CHUNKHDR;
                    n_phase  = PH_SKIP;
                end
            end

            if (err) begin
                n_failed      = 1'b1;
                cmd           = '0;
                cmd.main_vld  = 1'b1;
                cmd.main_kind = rcd_pkg::K_ERROR;
            end else if (nx == fs) begin
                cmd.done_vld = 1'b1;
                cmd.done_dls = n_seen[2];
                cmd.done_has = n_seen[3];
                cmd.done_off = off;
            end
        end
    end

    // Apply the default bank offset rules
    always_comb begin
        off = n_offset;
        if (n_seen[0] && !n_seen[1]) off = 16'd1;
        if (n_seen[2]) off = 16'd0;
        if (!n_seen[3]) off = 16'd0;
    end

    assign o_push = cmd.main_vld | cmd.done_vld;
    assign o_cmd  = cmd;

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEAD;
            r_resume    <= PH_HEAD;
            r_pos       <= '0;
            r_hb        <= '0;
            r_riff      <= '0;
            r_chunk_end <= '0;
            r_list_end  <= '0;
            r_field_end <= '0;
            r_skip      <= '0;
            r_field     <= '0;
            r_seen      <= '0;
            r_offset    <= '0;
            r_failed    <= 1'b0;
            r_hdr       <= '0;
        end else begin
            if (active) r_pos <= nx[31:0];
            r_phase     <= n_phase;
            r_resume    <= n_resume;
            r_hb        <= n_hb;
            r_riff      <= n_riff;
            r_chunk_end <= n_chunk_end;
            r_list_end  <= n_list_end;
            r_field_end <= n_field_end;
            r_skip      <= n_skip;
            r_field     <= n_field;
            r_seen      <= n_seen;
            r_offset    <= n_offset;
            r_failed    <= n_failed;
            r_hdr       <= n_hdr;
        end
    end

`ifndef SYNTHESIS
    // Once failed, the parser stays failed and pushes nothing
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed) else $error("failed flag cleared");
    a_failed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !o_push) else $error("push after failure");
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.main_kind == rcd_pkg::K_ERROR && o_cmd.main_vld) |-> !o_cmd.done_vld)
        else $error("error pushed with done");
`endif

endmodule
`default_nettype wire

>>> src/rcd_queue.sv
// Command queue between parser and output sequencer.
// Depends on rcd_pkg.
`default_nettype none
module rcd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rcd_pkg::t_cmd i_cmd,
    output logic               o_room,
    output logic               o_vld,
    output rcd_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    rcd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_room = (r_count < CW'(DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_cmd  = r_mem[r_rp];
    assign push   = i_push && o_room;
    assign pop    = i_pop && o_vld;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            if (pop)  r_rp <= (r_rp == LAST) ? '0 : r_rp + AW'(1);
            if (push && !pop) r_count <= r_count + CW'(1);
            else if (pop && !push) r_count <= r_count - CW'(1);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count overflow");
    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room) else $error("push into full queue");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> r_count == $past(r_count) - CW'(1)) else $error("pop miscount");
`endif

endmodule
`default_nettype wire

>>> src/rcd_back.sv
// Output sequencer: expands commands into result items, replays a bank
// header byte by byte and drives the output register. Depends on rcd_pkg, rcd_out_if.
`default_nettype none
module rcd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cvld,
    input  wire rcd_pkg::t_cmd i_cmd,
    output logic               o_pop,
    rcd_out_if.source          o_out
);

    logic          r_ovld;
    rcd_pkg::t_res r_res, res;
    logic [3:0]    r_cnt;
    logic          r_main_sent;
    logic          emit_main, fin_main, load;

    // Pick the next result of the head command
    always_comb begin
        res       = '0;
        emit_main = i_cmd.main_vld && !r_main_sent;
        fin_main  = 1'b1;
        if (emit_main) begin
            if (i_cmd.replay) begin
                res.kind            = rcd_pkg::K_BANK;
                res.out_byte        = i_cmd.hdr[r_cnt];
                res.first_of_region = (r_cnt == 4'd0);
                res.last_of_region  = (r_cnt == rcd_pkg::HDR_LAST) && i_cmd.replay_last;
                fin_main            = (r_cnt == rcd_pkg::HDR_LAST);
            end else begin
                res.kind            = i_cmd.main_kind;
                res.out_byte        = i_cmd.main_byte;
                res.field_code      = i_cmd.main_code;
                res.first_of_region = i_cmd.main_first;
                res.last_of_region  = i_cmd.main_last;
            end
        end else begin
            res.kind        = rcd_pkg::K_DONE;
            res.bank_ofs    = i_cmd.done_off;
            res.bank_is_dls = i_cmd.done_dls;
            res.has_bank    = i_cmd.done_has;
        end
    end

    assign load  = i_cvld && (!r_ovld || o_out.ready);
    assign o_pop = load && (!emit_main || (fin_main && !i_cmd.done_vld));

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld      <= 1'b0;
            r_cnt       <= '0;
            r_main_sent <= 1'b0;
        end else begin
            if (load) r_ovld <= 1'b1;
            else if (o_out.ready) r_ovld <= 1'b0;
            if (load && emit_main && i_cmd.replay) begin
                r_cnt <= fin_main ? 4'd0 : r_cnt + 4'd1;
            end
            if (load) begin
                if (emit_main && fin_main && i_cmd.done_vld) r_main_sent <= 1'b1;
                else if (!emit_main) r_main_sent <= 1'b0;
            end
        end
    end

    // Load output payload
    always_ff @(posedge i_clk) begin
        if (load) r_res <= res;
    end

    assign o_out.valid           = r_ovld;
    assign o_out.kind            = r_res.kind;
    assign o_out.out_byte        = r_res.out_byte;
    assign o_out.field_code      = r_res.field_code;
    assign o_out.first_of_region = r_res.first_of_region;
    assign o_out.last_of_region  = r_res.last_of_region;
    assign o_out.bank_ofs        = r_res.bank_ofs;
    assign o_out.bank_is_dls     = r_res.bank_is_dls;
    assign o_out.has_bank        = r_res.has_bank;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rcd_pkg::HDR_LAST) else $error("replay counter out of range");
    a_sent_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_sent |-> i_cvld) else $error("main sent without command");
    a_done_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_res.kind == rcd_pkg::K_DONE) |->
        (!r_res.first_of_region && !r_res.last_of_region)) else $error("done with region flags");
`endif

endmodule
`default_nettype wire

>>> src/rmid_riff_chunk_demux_unit.sv
// Top level of the RMID chunk demux: file size register, parser, queue, sequencer.
// Depends on rcd_pkg, rcd_in_if, rcd_out_if, rcd_front, rcd_queue, rcd_back.
//
//   port          dir   handshake      payload
//   i_in          in    valid/ready    data_byte[7:0]
//   o_out         out   valid/ready    kind, out_byte, field_code, region flags, summary
//   i_cfg_wr_*    in    write enable   file_size[31:0]
//
// One byte per cycle in; one result per cycle out. A bank header replay gives
// 12 results for one byte (13 when that byte also ends the file), so after
// QUEUE_DEPTH - 1 more requests the queue fills and input stalls until the
// replay command leaves the queue. Output is registered; a stall on o_out backs up
// through the queue to i_in.ready. Synchronous active-low reset.
`default_nettype none
module rmid_riff_chunk_demux_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    rcd_in_if.sink           i_in,
    rcd_out_if.source        o_out
);

    logic [31:0]   r_file_size;
    logic          room, push, q_vld, pop;
    rcd_pkg::t_cmd push_cmd, head_cmd;

    // Hold file size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_file_size <= '0;
        else if (i_cfg_wr_en) r_file_size <= i_cfg_wr_data;
    end

    rcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_file_size (r_file_size),
        .i_room      (room),
        .i_in        (i_in),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    rcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_room  (room),
        .o_vld   (q_vld),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    rcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cvld  (q_vld),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
